>>> design/vfo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the voxel face occlusion unit.
// Used by vfo_ctrl, vfo_datapath and voxel_face_occlusion_unit.
package vfo_pkg;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    localparam logic [7:0] TYPE_EMPTY = 8'h00;
    localparam logic [7:0] TYPE_WATER = 8'h77;
    localparam logic [7:0] TYPE_LEAF  = 8'h6C;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] REG_LEFT_PRESENT  = 2'd0;
    localparam logic [1:0] REG_RIGHT_PRESENT = 2'd1;
    localparam logic [1:0] REG_FRONT_PRESENT = 2'd2;
    localparam logic [1:0] REG_BACK_PRESENT  = 2'd3;

    typedef enum logic [2:0] {
        STEP_SELF  = 3'd0,
        STEP_UP    = 3'd1,
        STEP_DOWN  = 3'd2,
        STEP_LEFT  = 3'd3,
        STEP_RIGHT = 3'd4,
        STEP_FRONT = 3'd5,
        STEP_BACK  = 3'd6
    } step_t;

    typedef struct packed {
        logic  clear_en;
        logic  write_en;
        logic  load_item;
        logic  rd_en;
        step_t rd_sel;
        logic  finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } status_t;

    function automatic logic is_clear(input logic [7:0] t);
        return (t == TYPE_WATER) || (t == TYPE_LEAF);
    endfunction

    function automatic logic covers(input logic self_clear, input logic [7:0] nb);
        if (nb == TYPE_EMPTY) begin
            return 1'b0;
        end
        return self_clear || !is_clear(nb);
    endfunction

endpackage

>>> design/vfo_ctrl.sv
`timescale 1ns / 1ps
// Controller of the voxel face occlusion unit: clear pass, item intake, read sequence.
// Depends on vfo_pkg; drives the command struct of vfo_datapath.
module vfo_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_func,
    output logic             s_tready,
    output vfo_pkg::cmd_t    cmd,
    input  vfo_pkg::status_t st
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_QUERY = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    vfo_pkg::step_t step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= vfo_pkg::STEP_SELF;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = step_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (st.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_func == vfo_pkg::FUNC_WRITE) begin
                        cmd.write_en = 1'b1;
                    end else begin
                        cmd.load_item = 1'b1;
                        step_next     = vfo_pkg::STEP_SELF;
                        state_next    = ST_QUERY;
                    end
                end
            end
            ST_QUERY: begin
                cmd.rd_en = 1'b1;
                if (step_reg == vfo_pkg::STEP_BACK) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = vfo_pkg::step_t'(step_reg + 3'd1);
                end
            end
            ST_FIN: begin
                if (!st.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> design/vfo_datapath.sv
`timescale 1ns / 1ps
// Datapath of the voxel face occlusion unit: voxel memory, item registers,
// presence registers, face tests and output register. Depends on vfo_pkg.
module vfo_datapath #(
    parameter int SIDE = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  vfo_pkg::cmd_t                    cmd,
    output vfo_pkg::status_t                 st,
    input  logic [vfo_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic                             cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vfo_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int CW    = $clog2(SIDE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [7:0]    SIDE_W = 8'(SIDE);
    localparam logic [CW-1:0] LAST   = CW'(SIDE - 1);
    localparam logic [CW-1:0] ZERO   = '0;

    logic [7:0] mem [DEPTH];

    logic [3:0]    in_x, in_y, in_z;
    logic [7:0]    in_wt;
    logic          in_inside;
    logic [CW-1:0] cx, cy, cz;

    logic [AW-1:0] clr_cnt_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data_reg;
    logic          rd_vld_d_reg;
    vfo_pkg::step_t rd_sel_d_reg;

    logic          left_present_reg, right_present_reg;
    logic          front_present_reg, back_present_reg;

    logic [CW-1:0] x_reg, y_reg, z_reg;
    logic          inside_reg;
    logic [7:0]    a_left_reg, a_right_reg, a_front_reg, a_back_reg;
    logic [7:0]    self_reg, up_reg, down_reg, left_reg, right_reg, front_reg;

    logic          sc, top_h, bottom_h, left_h, right_h, front_h, back_h, all_h;
    logic [vfo_pkg::OUT_TDATA_W-1:0] result;
    logic [vfo_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic          m_tvalid_reg;

    assign in_x  = s_tdata[3:0];
    assign in_y  = s_tdata[7:4];
    assign in_z  = s_tdata[11:8];
    assign in_wt = s_tdata[19:12];
    assign in_inside = ({4'b0, in_x} < SIDE_W) && ({4'b0, in_y} < SIDE_W)
                    && ({4'b0, in_z} < SIDE_W);
    assign cx = CW'(in_x);
    assign cy = CW'(in_y);
    assign cz = CW'(in_z);

    // memory write port: clear sweep or item write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = vfo_pkg::TYPE_EMPTY;
        if (cmd.clear_en) begin
            wr_en = 1'b1;
        end else if (cmd.write_en && in_inside) begin
            wr_en   = 1'b1;
            wr_addr = {cx, cy, cz};
            wr_data = in_wt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_cnt_reg <= AW'(clr_cnt_reg + 1'b1);
        end
    end

    assign st.clear_last = &clr_cnt_reg;
    assign st.out_busy   = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            vfo_pkg::STEP_SELF:  rd_addr = {x_reg, y_reg, z_reg};
            vfo_pkg::STEP_UP:    rd_addr = {x_reg, CW'(y_reg + 1'b1), z_reg};
            vfo_pkg::STEP_DOWN:  rd_addr = {x_reg, CW'(y_reg - 1'b1), z_reg};
            vfo_pkg::STEP_LEFT:  rd_addr = {CW'(x_reg - 1'b1), y_reg, z_reg};
            vfo_pkg::STEP_RIGHT: rd_addr = {CW'(x_reg + 1'b1), y_reg, z_reg};
            vfo_pkg::STEP_FRONT: rd_addr = {x_reg, y_reg, CW'(z_reg + 1'b1)};
            vfo_pkg::STEP_BACK:  rd_addr = {x_reg, y_reg, CW'(z_reg - 1'b1)};
            default:             rd_addr = {x_reg, y_reg, z_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_d_reg <= 1'b0;
            rd_sel_d_reg <= vfo_pkg::STEP_SELF;
        end else begin
            rd_vld_d_reg <= cmd.rd_en;
            rd_sel_d_reg <= cmd.rd_sel;
        end
    end

    // capture neighbor reads; the last read stays in rd_data_reg
    always_ff @(posedge aclk) begin
        if (rd_vld_d_reg) begin
            case (rd_sel_d_reg)
                vfo_pkg::STEP_SELF:  self_reg  <= rd_data_reg;
                vfo_pkg::STEP_UP:    up_reg    <= rd_data_reg;
                vfo_pkg::STEP_DOWN:  down_reg  <= rd_data_reg;
                vfo_pkg::STEP_LEFT:  left_reg  <= rd_data_reg;
                vfo_pkg::STEP_RIGHT: right_reg <= rd_data_reg;
                vfo_pkg::STEP_FRONT: front_reg <= rd_data_reg;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            x_reg       <= cx;
            y_reg       <= cy;
            z_reg       <= cz;
            inside_reg  <= in_inside;
            a_left_reg  <= s_tdata[27:20];
            a_right_reg <= s_tdata[35:28];
            a_front_reg <= s_tdata[43:36];
            a_back_reg  <= s_tdata[51:44];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_present_reg  <= 1'b0;
            right_present_reg <= 1'b0;
            front_present_reg <= 1'b0;
            back_present_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vfo_pkg::REG_LEFT_PRESENT:  left_present_reg  <= cfg_wdata;
                vfo_pkg::REG_RIGHT_PRESENT: right_present_reg <= cfg_wdata;
                vfo_pkg::REG_FRONT_PRESENT: front_present_reg <= cfg_wdata;
                vfo_pkg::REG_BACK_PRESENT:  back_present_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sc       = vfo_pkg::is_clear(self_reg);
        top_h    = (y_reg == LAST) ? 1'b0 : vfo_pkg::covers(sc, up_reg);
        bottom_h = (y_reg == ZERO) ? 1'b1 : vfo_pkg::covers(sc, down_reg);
        if (x_reg == ZERO) begin
            left_h = !left_present_reg || vfo_pkg::covers(sc, a_left_reg);
        end else begin
            left_h = vfo_pkg::covers(sc, left_reg);
        end
        if (x_reg == LAST) begin
            right_h = !right_present_reg || vfo_pkg::covers(sc, a_right_reg);
        end else begin
            right_h = vfo_pkg::covers(sc, right_reg);
        end
        if (z_reg == LAST) begin
            front_h = !front_present_reg || vfo_pkg::covers(sc, a_front_reg);
        end else begin
            front_h = vfo_pkg::covers(sc, front_reg);
        end
        if (z_reg == ZERO) begin
            back_h = !back_present_reg || vfo_pkg::covers(sc, a_back_reg);
        end else begin
            back_h = vfo_pkg::covers(sc, rd_data_reg);
        end
        all_h  = top_h & bottom_h & left_h & right_h & front_h & back_h;
        result = {sc, self_reg, all_h, back_h, front_h, right_h, left_h, bottom_h, top_h};
        if (!inside_reg) begin
            result = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> design/voxel_face_occlusion_unit.sv
`timescale 1ns / 1ps
// Voxel face occlusion unit: top level joining vfo_ctrl and vfo_datapath.
// Depends on vfo_pkg.
//
// Input stream (s_): s_tuser is the function, write cell or query cell. A write
// stores one 8-bit type code and gives no result. A query reads the cell and
// its six neighbors one at a time from the single read port of the voxel
// memory, then tests the faces and registers the result on m_; the next item
// is accepted only after that result is registered.
// Output stream (m_): one item per query, held in an output register. While it
// waits, writes are still accepted; a further query finishes its reads and then
// holds until the register is taken.
// Configuration: cfg_wr_en writes cfg_wdata into chunk presence register
// cfg_index (0 left, 1 right, 2 front, 3 back); write only while idle.
// Reset: presence registers clear, then the voxel memory is swept to empty at
// one cell per cycle over all 2**(3*clog2(SIDE)) cells (4096 at SIDE 16), with
// s_tready low. Configuration writes are taken during the sweep.
module voxel_face_occlusion_unit #(
    parameter int SIDE = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x[3:0], pos_y[7:4], pos_z[11:8], write_type[19:12],
    // across_left_type[27:20], across_right_type[35:28],
    // across_front_type[43:36], across_back_type[51:44], zero fill[55:52]
    input  logic [vfo_pkg::IN_TDATA_W-1:0]   s_tdata,
    // func[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // top_hidden[0], bottom_hidden[1], left_hidden[2], right_hidden[3],
    // front_hidden[4], back_hidden[5], all_hidden[6], cell_type[14:7],
    // cell_transparent[15]
    output logic [vfo_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic                             cfg_wdata
);

    vfo_pkg::cmd_t    cmd;
    vfo_pkg::status_t st;

    vfo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    vfo_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_no_intake_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_en |-> !s_tready)
        else $error("item intake during memory clear");

    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_tvalid || m_tready))
        else $error("result overwrites an untaken item");

    a_write_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_en |-> (s_tvalid && s_tready && s_tuser == vfo_pkg::FUNC_WRITE))
        else $error("memory write without an accepted write item");

    a_query_starts_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |=> (cmd.rd_en && cmd.rd_sel == vfo_pkg::STEP_SELF))
        else $error("query did not start with the cell read");
`endif

endmodule

>>> tb/voxel_face_occlusion_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of voxel_face_occlusion_unit: random cell writes and
// face queries on the stream ports, predicted by its own voxel grid copy.
// Depends on vfo_pkg and the voxel_face_occlusion_unit RTL.
module voxel_face_occlusion_unit_tb;

    localparam int SIDE = 16;
    localparam int LAST = SIDE - 1;

    // Input item as packed on s_tdata, lowest field last.
    typedef struct packed {
        logic [3:0] fill;
        logic [7:0] back_t;
        logic [7:0] front_t;
        logic [7:0] right_t;
        logic [7:0] left_t;
        logic [7:0] wtype;
        logic [3:0] z;
        logic [3:0] y;
        logic [3:0] x;
    } cell_item_t;

    // Result item as packed on m_tdata, lowest field last.
    typedef struct packed {
        logic       transparent;
        logic [7:0] ctype;
        logic       all_h;
        logic       back_h;
        logic       front_h;
        logic       right_h;
        logic       left_h;
        logic       bottom_h;
        logic       top_h;
    } face_result_t;

    class occlusion_scoreboard;
        logic [7:0]   voxels [SIDE*SIDE*SIDE];
        logic [3:0]   presence;
        face_result_t face_q [$];
        int errors;
        int checked;
        int writes;
        int queries;

        function new();
            foreach (voxels[i]) voxels[i] = vfo_pkg::TYPE_EMPTY;
            presence = '0;
            errors   = 0;
            checked  = 0;
            writes   = 0;
            queries  = 0;
        endfunction

        function int pending();
            return face_q.size();
        endfunction

        function void set_presence(logic [1:0] idx, logic v);
            presence[idx] = v;
        endfunction

        function logic see_through(logic [7:0] t);
            return (t == vfo_pkg::TYPE_WATER) || (t == vfo_pkg::TYPE_LEAF);
        endfunction

        function logic shades(logic self_clear, logic [7:0] nb);
            return (nb != vfo_pkg::TYPE_EMPTY) && (self_clear || !see_through(nb));
        endfunction

        function logic [7:0] voxel(int x, int y, int z);
            return voxels[(x * SIDE + y) * SIDE + z];
        endfunction

        function logic edge_face(logic sc, logic at_edge, logic present,
                                 logic [7:0] across, logic [7:0] inner);
            if (at_edge) return present ? shades(sc, across) : 1'b1;
            return shades(sc, inner);
        endfunction

        function void note_item(logic fn, cell_item_t it);
            face_result_t r;
            int x, y, z;
            logic sc;
            logic [7:0] self_t;
            x = it.x;
            y = it.y;
            z = it.z;
            if (fn == vfo_pkg::FUNC_WRITE) begin
                voxels[(x * SIDE + y) * SIDE + z] = it.wtype;
                writes++;
                return;
            end
            queries++;
            self_t = voxel(x, y, z);
            sc = see_through(self_t);
            r = '0;
            r.top_h = (y == LAST) ? 1'b0 : shades(sc, voxel(x, y + 1, z));
            r.bottom_h = (y == 0) ? 1'b1 : shades(sc, voxel(x, y - 1, z));
            r.left_h = edge_face(sc, x == 0, presence[vfo_pkg::REG_LEFT_PRESENT],
                                 it.left_t,
                                 (x == 0) ? vfo_pkg::TYPE_EMPTY : voxel(x - 1, y, z));
            r.right_h = edge_face(sc, x == LAST, presence[vfo_pkg::REG_RIGHT_PRESENT],
                                  it.right_t,
                                  (x == LAST) ? vfo_pkg::TYPE_EMPTY : voxel(x + 1, y, z));
            r.front_h = edge_face(sc, z == LAST, presence[vfo_pkg::REG_FRONT_PRESENT],
                                  it.front_t,
                                  (z == LAST) ? vfo_pkg::TYPE_EMPTY : voxel(x, y, z + 1));
            r.back_h = edge_face(sc, z == 0, presence[vfo_pkg::REG_BACK_PRESENT],
                                 it.back_t,
                                 (z == 0) ? vfo_pkg::TYPE_EMPTY : voxel(x, y, z - 1));
            r.all_h = r.top_h & r.bottom_h & r.left_h & r.right_h & r.front_h & r.back_h;
            r.ctype = self_t;
            r.transparent = sc;
            face_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("%0t ns: %s", $time, msg);
        endtask

        task compare(string field, int got, int want);
            if (got != want)
                report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                 checked, field, got, want));
        endtask

        task check_result(logic [vfo_pkg::OUT_TDATA_W-1:0] data);
            face_result_t got;
            face_result_t want;
            got = face_result_t'(data);
            if (face_q.size() == 0) begin
                report($sformatf("result 0x%0h with no query outstanding", data));
                return;
            end
            want = face_q.pop_front();
            compare("top_hidden", got.top_h, want.top_h);
            compare("bottom_hidden", got.bottom_h, want.bottom_h);
            compare("left_hidden", got.left_h, want.left_h);
            compare("right_hidden", got.right_h, want.right_h);
            compare("front_hidden", got.front_h, want.front_h);
            compare("back_hidden", got.back_h, want.back_h);
            compare("all_hidden", got.all_h, want.all_h);
            compare("cell_type", got.ctype, want.ctype);
            compare("cell_transparent", got.transparent, want.transparent);
            checked++;
        endtask
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [vfo_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [vfo_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_wr_en;
    logic [1:0]                      cfg_index;
    logic                            cfg_wdata;

    occlusion_scoreboard sb = new();
    int  sent = 0;
    int  settings_used = 0;
    int  quiet_left = 0;
    bit  hold_request = 1'b0;

    always #5 aclk = ~aclk;

    voxel_face_occlusion_unit #(.SIDE(SIDE)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    function automatic logic [7:0] pick_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return vfo_pkg::TYPE_EMPTY;
        if (r < 35) return vfo_pkg::TYPE_WATER;
        if (r < 50) return vfo_pkg::TYPE_LEAF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_coord();
        if ($urandom_range(0, 99) < 35) return $urandom_range(0, 1) ? LAST : 0;
        return $urandom_range(0, LAST);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) quiet_left = $urandom_range(20, 60);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic cell_item_t make_item(int x, int y, int z, logic [7:0] wt);
        cell_item_t it;
        it.fill    = '0;
        it.x       = 4'(x);
        it.y       = 4'(y);
        it.z       = 4'(z);
        it.wtype   = wt;
        it.left_t  = pick_type();
        it.right_t = pick_type();
        it.front_t = pick_type();
        it.back_t  = pick_type();
        return it;
    endfunction

    task automatic send_item(input logic fn, input cell_item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= it;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(fn, it);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_cell(input int x, input int y, input int z, input logic [7:0] t);
        send_item(vfo_pkg::FUNC_WRITE, make_item(x, y, z, t));
    endtask

    task automatic query_cell(input int x, input int y, input int z, input logic [7:0] al,
                              input logic [7:0] ar, input logic [7:0] af,
                              input logic [7:0] ab);
        cell_item_t it;
        it = make_item(x, y, z, 8'($urandom_range(0, 255)));
        it.left_t  = al;
        it.right_t = ar;
        it.front_t = af;
        it.back_t  = ab;
        send_item(vfo_pkg::FUNC_QUERY, it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_presence(input logic [3:0] v);
        logic [1:0] regs [4];
        regs = '{vfo_pkg::REG_LEFT_PRESENT, vfo_pkg::REG_RIGHT_PRESENT,
                 vfo_pkg::REG_FRONT_PRESENT, vfo_pkg::REG_BACK_PRESENT};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= v[i];
            sb.set_presence(regs[i], v[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Fill some of a cell's neighborhood, then query it and maybe a neighbor.
    task automatic run_cluster();
        int ofs_x [7];
        int ofs_y [7];
        int ofs_z [7];
        int cx, cy, cz, nx, ny, nz, k;
        ofs_x = '{0, 0, 0, -1, 1, 0, 0};
        ofs_y = '{0, 1, -1, 0, 0, 0, 0};
        ofs_z = '{0, 0, 0, 0, 0, 1, -1};
        cx = pick_coord();
        cy = pick_coord();
        cz = pick_coord();
        for (int i = 0; i < 7; i++) begin
            nx = cx + ofs_x[i];
            ny = cy + ofs_y[i];
            nz = cz + ofs_z[i];
            if (nx >= 0 && nx <= LAST && ny >= 0 && ny <= LAST && nz >= 0 && nz <= LAST
                && $urandom_range(0, 9) < 7)
                write_cell(nx, ny, nz, pick_type());
        end
        send_item(vfo_pkg::FUNC_QUERY, make_item(cx, cy, cz, 8'($urandom_range(0, 255))));
        if ($urandom_range(0, 9) < 3) begin
            k = $urandom_range(1, 6);
            nx = cx + ofs_x[k];
            ny = cy + ofs_y[k];
            nz = cz + ofs_z[k];
            if (nx >= 0 && nx <= LAST && ny >= 0 && ny <= LAST && nz >= 0 && nz <= LAST)
                send_item(vfo_pkg::FUNC_QUERY,
                          make_item(nx, ny, nz, 8'($urandom_range(0, 255))));
        end
    endtask

    initial begin
        int ready_left;
        int r;
        ready_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_result(m_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                ready_left = 300;
            end else if (ready_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    ready_left = $urandom_range(1, 12);
                end else if (r < 65) begin
                    m_tready <= 1'b1;
                    ready_left = $urandom_range(50, 200);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    ready_left = $urandom_range(1, 4);
                end else begin
                    m_tready <= 1'b0;
                    ready_left = $urandom_range(20, 60);
                end
            end else begin
                ready_left--;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [3:0] phase_cfg [6];
        int target;
        int r;
        bit held;
        bit paused;
        phase_cfg = '{4'b0000, 4'b1111, 4'b0110, 4'b1001, 4'b0000, 4'b0000};
        held      = 1'b0;
        paused    = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= vfo_pkg::FUNC_WRITE;
        cfg_wr_en <= 1'b0;
        cfg_index <= vfo_pkg::REG_LEFT_PRESENT;
        cfg_wdata <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_presence(4'b0000);
        query_cell(0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        query_cell(LAST, LAST, LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        write_cell(0, 0, 0, 8'hFF);
        write_cell(0, 1, 0, vfo_pkg::TYPE_WATER);
        write_cell(1, 0, 0, vfo_pkg::TYPE_LEAF);
        write_cell(0, 0, 1, 8'h01);
        query_cell(0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        write_cell(0, 0, 0, vfo_pkg::TYPE_WATER);
        query_cell(0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        write_cell(0, 0, 0, vfo_pkg::TYPE_LEAF);
        query_cell(0, 0, 0, 8'h55, 8'hAA, 8'h55, 8'hAA);
        write_cell(LAST, LAST, LAST, 8'h80);
        write_cell(LAST, LAST - 1, LAST, 8'h7F);
        write_cell(LAST - 1, LAST, LAST, vfo_pkg::TYPE_WATER);
        write_cell(LAST, LAST, LAST - 1, vfo_pkg::TYPE_LEAF);
        query_cell(LAST, LAST, LAST, 8'h00, 8'h00, 8'h00, 8'h00);
        query_cell(0, 1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        write_presence(4'b1111);
        query_cell(0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        query_cell(0, 0, 0, vfo_pkg::TYPE_WATER, vfo_pkg::TYPE_WATER,
                   vfo_pkg::TYPE_WATER, vfo_pkg::TYPE_WATER);
        query_cell(LAST, LAST, LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        query_cell(LAST, LAST, LAST, vfo_pkg::TYPE_LEAF, vfo_pkg::TYPE_WATER,
                   vfo_pkg::TYPE_LEAF, vfo_pkg::TYPE_WATER);
        write_cell(0, 1, 0, vfo_pkg::TYPE_EMPTY);
        query_cell(0, 1, 0, 8'h01, 8'h80, 8'hFE, 8'h7F);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            if (p >= 4) phase_cfg[p] = 4'($urandom_range(0, 15));
            write_presence(phase_cfg[p]);
            target = sent + 290;
            paused = 1'b0;
            while (sent < target) begin
                if (p == 1 && !held && sent >= target - 200) begin
                    hold_request = 1'b1;
                    held = 1'b1;
                end
                if (!paused && sent >= target - 145) begin
                    paused = 1'b1;
                    wait_drained();
                end
                r = $urandom_range(0, 99);
                if (r < 65)
                    run_cluster();
                else if (r < 85)
                    send_item(vfo_pkg::FUNC_QUERY, make_item($urandom_range(0, LAST),
                              $urandom_range(0, LAST), $urandom_range(0, LAST),
                              8'($urandom_range(0, 255))));
                else
                    write_cell($urandom_range(0, LAST), $urandom_range(0, LAST),
                               $urandom_range(0, LAST), pick_type());
            end
            wait_drained();
        end

        $display("Sent %0d items (%0d writes, %0d queries) under %0d presence settings.",
                 sent, sb.writes, sb.queries, settings_used);
        $display("Checked %0d face results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
